### rtl/core/mpl_pkg.sv
package mpl_pkg;

    localparam int NumPorts = 4;
    localparam int PortW    = 8;
    localparam int PortIdxW = 2;
    localparam int PinIdxW  = 3;
    localparam int CtlW     = 7;
    localparam int NestW    = 2;

    localparam logic [PortW-1:0]    LATCH_RESET = 8'hFF;
    localparam logic [PortIdxW-1:0] INT_PORT    = 2'd3;
    localparam int                  INT0_BIT    = 2;
    localparam int                  INT1_BIT    = 3;

    // interrupt_control bit positions
    localparam int CTL_EA  = 0;
    localparam int CTL_IT0 = 1;
    localparam int CTL_IT1 = 2;
    localparam int CTL_EX0 = 3;
    localparam int CTL_EX1 = 4;
    localparam int CTL_PX0 = 5;
    localparam int CTL_PX1 = 6;

    typedef enum logic [2:0] {
        OP_RESET      = 3'd0,
        OP_TICK       = 3'd1,
        OP_PORT_WRITE = 3'd2,
        OP_PIN_WRITE  = 3'd3,
        OP_PORT_READ  = 3'd4,
        OP_IRQ_ENTER  = 3'd5,
        OP_IRQ_EXIT   = 3'd6,
        OP_LATCH_LOAD = 3'd7
    } op_t;

    typedef struct packed {
        op_t                 operation;
        logic [PortIdxW-1:0] port_index;
        logic [PinIdxW-1:0]  pin_index;
        logic [PortW-1:0]    value;
        logic [CtlW-1:0]     interrupt_control;
        logic [NestW-1:0]    nesting_level;
        logic                interrupt_source;
    } item_t;

    typedef struct packed {
        logic [PortW-1:0] read_data;
        logic             set_ie0;
        logic             set_ie1;
        logic             clear_ie0;
        logic             clear_ie1;
        logic             request_int0;
        logic             request_int0_high;
        logic             request_int1;
        logic             request_int1_high;
    } result_t;

    // pipeline handshake between the output stage and the rest
    typedef struct packed {
        logic take;  // output stage can take a result this cycle
        logic fire;  // held item moves to the output stage this cycle
    } flow_t;

    // {request, high} for an enabled source; high priority allowed at depth < 2,
    // low priority only at depth 0
    function automatic logic [1:0] irq_request(
        input logic             ex,
        input logic             px,
        input logic [NestW-1:0] nest
    );
        logic [1:0] r;
        r = 2'b00;
        if (ex)
        begin
            if (px)
            begin
                if (nest < NestW'(2))
                    r = 2'b11;
            end
            else if (nest == '0)
            begin
                r = 2'b10;
            end
        end
        return r;
    endfunction

endpackage

### rtl/core/mpl_in_reg.sv
module mpl_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  mpl_pkg::item_t in_item,
    input  mpl_pkg::flow_t flow,
    output logic          item_valid,
    output mpl_pkg::item_t item
);
    import mpl_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign in_stall   = valid_reg && !flow.take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (flow.fire ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/core/mpl_core.sv
module mpl_core (
    input  logic            clk,
    input  logic            rst_n,
    input  mpl_pkg::item_t  item,
    input  mpl_pkg::flow_t  flow,
    output mpl_pkg::result_t result
);
    import mpl_pkg::*;

    logic [PortW-1:0] latch_reg  [NumPorts];
    logic [PortW-1:0] latch_next [NumPorts];
    logic [1:0]       pending_reg;
    logic [1:0]       pending_next;

    logic [PortW-1:0] cur;
    logic [PortW-1:0] p3;
    logic [PortW-1:0] wdata;
    logic [PortW-1:0] pin_mask;
    logic             wr;
    logic             wr_int_port;
    logic             hit0;
    logic             hit1;
    logic [1:0]       req0;
    logic [1:0]       req1;
    logic             ea;

    assign cur      = latch_reg[item.port_index];
    assign p3       = latch_reg[INT_PORT];
    assign ea       = item.interrupt_control[CTL_EA];
    assign pin_mask = PortW'(1) << item.pin_index;

    always_comb
    begin
        for (int i = 0; i < NumPorts; i++)
            latch_next[i] = latch_reg[i];
        pending_next = pending_reg;
        wdata        = item.value;
        wr           = 1'b0;
        hit0         = 1'b0;
        hit1         = 1'b0;
        result       = '0;

        case (item.operation)
            OP_RESET:
            begin
                for (int i = 0; i < NumPorts; i++)
                    latch_next[i] = LATCH_RESET;
                pending_next = 2'b00;
            end
            OP_TICK:
            begin
                // level-triggered sources, gated by EA
                hit0 = ea && !p3[INT0_BIT] && !item.interrupt_control[CTL_IT0];
                hit1 = ea && !p3[INT1_BIT] && !item.interrupt_control[CTL_IT1];
            end
            OP_PORT_WRITE:
            begin
                wr = 1'b1;
            end
            OP_PIN_WRITE:
            begin
                wr    = 1'b1;
                wdata = item.value[0] ? (cur | pin_mask) : (cur & ~pin_mask);
            end
            OP_PORT_READ:
            begin
            end
            OP_IRQ_ENTER:
            begin
                pending_next[item.interrupt_source] = 1'b1;
            end
            OP_IRQ_EXIT:
            begin
                result.clear_ie0 = pending_reg[0];
                result.clear_ie1 = pending_reg[1];
                pending_next     = 2'b00;
            end
            OP_LATCH_LOAD:
            begin
                // core-side load, no edge detection
                latch_next[item.port_index] = item.value;
            end
            default:
            begin
            end
        endcase

        wr_int_port = wr && (item.port_index == INT_PORT);
        if (wr)
            latch_next[item.port_index] = wdata;
        // falling edge on INT0/INT1 pins, EA not checked here
        if (wr_int_port && p3[INT0_BIT] && !wdata[INT0_BIT]
                && item.interrupt_control[CTL_IT0])
            hit0 = 1'b1;
        if (wr_int_port && p3[INT1_BIT] && !wdata[INT1_BIT]
                && item.interrupt_control[CTL_IT1])
            hit1 = 1'b1;

        req0 = irq_request(item.interrupt_control[CTL_EX0],
                           item.interrupt_control[CTL_PX0], item.nesting_level);
        req1 = irq_request(item.interrupt_control[CTL_EX1],
                           item.interrupt_control[CTL_PX1], item.nesting_level);

        result.read_data         = latch_next[item.port_index];
        result.set_ie0           = hit0;
        result.set_ie1           = hit1;
        result.request_int0      = hit0 && req0[1];
        result.request_int0_high = hit0 && req0[0];
        result.request_int1      = hit1 && req1[1];
        result.request_int1_high = hit1 && req1[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumPorts; i++)
                latch_reg[i] <= LATCH_RESET;
            pending_reg <= 2'b00;
        end
        else if (flow.fire)
        begin
            for (int i = 0; i < NumPorts; i++)
                latch_reg[i] <= latch_next[i];
            pending_reg <= pending_next;
        end
    end

endmodule

### rtl/core/mpl_out_reg.sv
module mpl_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  mpl_pkg::result_t result,
    output mpl_pkg::flow_t   flow,
    output logic             out_valid,
    input  logic             out_stall,
    output mpl_pkg::result_t out_result
);
    import mpl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign flow.take  = !valid_reg || !out_stall;
    assign flow.fire  = item_valid && flow.take;
    assign valid_next = flow.fire || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (flow.fire)
            result_reg <= result;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

### rtl/core/mcu_port_latch_ext_interrupt.sv
// 8051 port latches P0..P3 with external interrupt 0/1 detection. Every beat
// is one operation (reset, tick, port/pin write, read, irq enter/exit, latch
// load) and returns exactly one result beat. The beat sits in an input
// register, passes one level of bit logic against the four latches and the
// pending-clear marks, and lands in the result register, which drives
// out_valid; one beat is taken every cycle as long as out_stall stays low.
// Falling edges on P3.2/P3.3 are detected only on port and pin writes to port 3;
// latch loads update silently.
module mcu_port_latch_ext_interrupt (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    operation,
    input  logic [mpl_pkg::PortIdxW-1:0]  port_index,
    input  logic [mpl_pkg::PinIdxW-1:0]   pin_index,
    input  logic [mpl_pkg::PortW-1:0]     value,
    input  logic [mpl_pkg::CtlW-1:0]      interrupt_control,
    input  logic [mpl_pkg::NestW-1:0]     nesting_level,
    input  logic                          interrupt_source,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mpl_pkg::PortW-1:0]     read_data,
    output logic                          set_ie0,
    output logic                          set_ie1,
    output logic                          clear_ie0,
    output logic                          clear_ie1,
    output logic                          request_int0,
    output logic                          request_int0_high,
    output logic                          request_int1,
    output logic                          request_int1_high
);
    import mpl_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    flow_t   flow;
    result_t result;
    result_t out_result;

    always_comb
    begin
        in_item.operation         = op_t'(operation);
        in_item.port_index        = port_index;
        in_item.pin_index         = pin_index;
        in_item.value             = value;
        in_item.interrupt_control = interrupt_control;
        in_item.nesting_level     = nesting_level;
        in_item.interrupt_source  = interrupt_source;
    end

    mpl_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .flow       (flow),
        .item_valid (item_valid),
        .item       (item)
    );

    mpl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .flow   (flow),
        .result (result)
    );

    mpl_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .flow       (flow),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign read_data         = out_result.read_data;
    assign set_ie0           = out_result.set_ie0;
    assign set_ie1           = out_result.set_ie1;
    assign clear_ie0         = out_result.clear_ie0;
    assign clear_ie1         = out_result.clear_ie1;
    assign request_int0      = out_result.request_int0;
    assign request_int0_high = out_result.request_int0_high;
    assign request_int1      = out_result.request_int1;
    assign request_int1_high = out_result.request_int1_high;

endmodule
